### src/ccd_pkg.sv
package ccd_pkg;

  // Field widths of the time and date counters.
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 7;
  localparam int SHIFT_W = 2;

  // Switch-day table layout: six 10-bit entries, start day low, end day high.
  localparam int TABLE_ENTRIES = 6;
  localparam int ENTRY_W       = 10;
  localparam int TABLE_W       = TABLE_ENTRIES * ENTRY_W;
  localparam int ENTRY_IDX_W   = $clog2(TABLE_ENTRIES);

  // Configuration port geometry: 64-bit registers at byte address 8*i.
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SHIFT_HOURS = 3'd0,
    CFG_START_MONTH = 3'd1,
    CFG_START_HOUR  = 3'd2,
    CFG_END_MONTH   = 3'd3,
    CFG_END_HOUR    = 3'd4,
    CFG_FIRST_YEAR  = 3'd5,
    CFG_DAY_TABLE   = 3'd6
  } ccd_cfg_index_t;

  // Register reset values.
  localparam logic [SHIFT_W-1:0] RST_SHIFT_HOURS = 2'd1;
  localparam logic [MONTH_W-1:0] RST_START_MONTH = 4'd3;
  localparam logic [HOUR_W-1:0]  RST_START_HOUR  = 5'd2;
  localparam logic [MONTH_W-1:0] RST_END_MONTH   = 4'd10;
  localparam logic [HOUR_W-1:0]  RST_END_HOUR    = 5'd3;
  localparam logic [YEAR_W-1:0]  RST_FIRST_YEAR  = 7'd9;

  // Calendar constants.
  localparam logic [SEC_W-1:0]   LAST_SECOND   = 6'd59;
  localparam logic [MIN_W-1:0]   LAST_MINUTE   = 6'd59;
  localparam logic [5:0]         HOURS_PER_DAY = 6'd24;
  localparam logic [4:0]         MONTHS_WRAP   = 5'd13;
  localparam logic [YEAR_W-1:0]  LAST_YEAR     = 7'd99;
  localparam logic [MONTH_W-1:0] FEBRUARY      = 4'd2;

  // Daylight-saving rule taken from the configuration registers.
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [MONTH_W-1:0] start_month;
    logic [HOUR_W-1:0]  start_hour;
    logic [MONTH_W-1:0] end_month;
    logic [HOUR_W-1:0]  end_hour;
  } ccd_rule_t;

  // Switch days for the current year; zero means no switch.
  typedef struct packed {
    logic [DAY_W-1:0] start_day;
    logic [DAY_W-1:0] end_day;
  } ccd_days_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } ccd_date_t;

  // Outcome of the hourly step.
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    ccd_date_t         date;
    logic              end_switched;
    logic              rolled;
  } ccd_hour_res_t;

  // Month length; unused month codes count as 31 days.
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic [YEAR_W-1:0] year);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd2:                   len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    if (month == FEBRUARY && year[1:0] == 2'b00) begin
      len = 5'd29;
    end
    return len;
  endfunction

endpackage

### src/ccd_dst_lookup.sv
module ccd_dst_lookup import ccd_pkg::*; #(
  parameter int DST_YEARS = 6
) (
  input  logic [YEAR_W-1:0]  year,
  input  logic [YEAR_W-1:0]  first_year,
  input  logic [TABLE_W-1:0] day_table,
  output ccd_days_t          days
);

  logic [YEAR_W-1:0] idx;
  logic              in_range;

  // Years before the first entry or past the last one get no switch.
  assign idx      = year - first_year;
  assign in_range = (year >= first_year) && (idx < YEAR_W'(DST_YEARS));

  // Pick this year's entry out of the packed table.
  always_comb begin
    days = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (in_range && idx[ENTRY_IDX_W-1:0] == ENTRY_IDX_W'(i) &&
          idx[YEAR_W-1:ENTRY_IDX_W] == '0) begin
        days.start_day = day_table[i*ENTRY_W +: DAY_W];
        days.end_day   = day_table[i*ENTRY_W + DAY_W +: DAY_W];
      end
    end
  end

endmodule

### src/ccd_hour_step.sv
module ccd_hour_step import ccd_pkg::*; (
  input  logic [HOUR_W-1:0] hour,
  input  ccd_date_t         date,
  input  logic              end_switched,
  input  ccd_rule_t         rule,
  input  ccd_days_t         days,
  output ccd_hour_res_t     res
);

  logic [5:0]        std_hour;
  logic [5:0]        start_hour;
  logic [5:0]        end_hour;
  logic [5:0]        shift_ext;
  logic              start_hit;
  logic              end_hit;
  logic [5:0]        new_day;
  logic [4:0]        new_month;

  assign shift_ext = {4'd0, rule.shift};

  // Summer-time start adds the shift when the new hour hits the start hour.
  assign start_hit = (date.month == rule.start_month) && (days.start_day != '0) &&
                     (date.day == days.start_day) &&
                     ({1'b0, hour} + 6'd1 == {1'b0, rule.start_hour});
  assign start_hour = {1'b0, hour} + 6'd1 + (start_hit ? shift_ext : 6'd0);

  // Summer-time end removes the shift once per day, saturating at zero.
  assign end_hit = !end_switched && (date.month == rule.end_month) &&
                   (days.end_day != '0) && (date.day == days.end_day) &&
                   (start_hour == {1'b0, rule.end_hour});
  assign end_hour = !end_hit ? start_hour :
                    (start_hour >= shift_ext) ? start_hour - shift_ext : 6'd0;

  assign std_hour  = end_hour;
  assign new_day   = {1'b0, date.day} + 6'd1;
  assign new_month = {1'b0, date.month} + 5'd1;

  // Midnight rollover advances day, month and year.
  always_comb begin
    res.date         = date;
    res.end_switched = end_switched | end_hit;
    res.rolled       = 1'b0;
    res.hour         = std_hour[HOUR_W-1:0];
    if (std_hour >= HOURS_PER_DAY) begin
      res.rolled       = 1'b1;
      res.end_switched = 1'b0;
      res.hour         = HOUR_W'(std_hour - HOURS_PER_DAY);
      res.date.day     = new_day[DAY_W-1:0];
      if (new_day > {1'b0, days_in(date.month, date.year)}) begin
        res.date.day   = 5'd1;
        res.date.month = new_month[MONTH_W-1:0];
        if (new_month >= MONTHS_WRAP) begin
          res.date.month = 4'd1;
          res.date.year  = (date.year >= LAST_YEAR) ? '0 : date.year + 7'd1;
        end
      end
    end
  end

endmodule

### src/calendar_clock_with_dst_top.sv
// Real-time clock calendar with a daylight-saving switch. Every accepted word
// is either a one-second tick or a load of time and date, and each one gives
// exactly one result word with the counters after it, a day-rollover pulse
// (use it as the save trigger) and the "summer time ended today" flag. A word
// is taken whenever the result register is empty or drains: the whole update
// is one pass of compare and increment logic from the counter registers into
// the result register, so the rate is one word per cycle unless the receiver
// stalls. The input side keeps taking words while a result waits, as long as
// that result leaves the output register in the same cycle. Switch days for
// up to DST_YEARS years sit in a packed 60-bit register; other years never
// switch. All registers are 64 bits wide at byte address 8*i; the user must
// write them only while the block is idle, which the block does not enforce.
module calendar_clock_with_dst_top import ccd_pkg::*; #(
  parameter int DST_YEARS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [SEC_W-1:0]      in_load_second,
  input  logic [MIN_W-1:0]      in_load_minute,
  input  logic [HOUR_W-1:0]     in_load_hour,
  input  logic [DAY_W-1:0]      in_load_day,
  input  logic [MONTH_W-1:0]    in_load_month,
  input  logic [YEAR_W-1:0]     in_load_year,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SEC_W-1:0]      out_second,
  output logic [MIN_W-1:0]      out_minute,
  output logic [HOUR_W-1:0]     out_hour,
  output logic [DAY_W-1:0]      out_day,
  output logic [MONTH_W-1:0]    out_month,
  output logic [YEAR_W-1:0]     out_year,
  output logic                  out_day_rolled,
  output logic                  out_dst_end_done
);

  ccd_rule_t           rule_r;
  logic [YEAR_W-1:0]   first_year_r;
  logic [TABLE_W-1:0]  day_table_r;

  logic [SEC_W-1:0]    sec_r, sec_nxt;
  logic [MIN_W-1:0]    min_r, min_nxt;
  logic [HOUR_W-1:0]   hour_r, hour_nxt;
  ccd_date_t           date_r, date_nxt;
  logic                end_sw_r, end_sw_nxt;
  logic                rolled_nxt;

  logic                out_valid_r;
  logic [SEC_W-1:0]    out_sec_r;
  logic [MIN_W-1:0]    out_min_r;
  logic [HOUR_W-1:0]   out_hour_r;
  ccd_date_t           out_date_r;
  logic                out_rolled_r;
  logic                out_end_r;

  logic                cfg_wr;
  logic                accept;
  ccd_cfg_index_t      cfg_idx;
  ccd_days_t           days;
  ccd_hour_res_t       hour_res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = ccd_cfg_index_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_INDEX_W]);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r.shift       <= RST_SHIFT_HOURS;
      rule_r.start_month <= RST_START_MONTH;
      rule_r.start_hour  <= RST_START_HOUR;
      rule_r.end_month   <= RST_END_MONTH;
      rule_r.end_hour    <= RST_END_HOUR;
      first_year_r       <= RST_FIRST_YEAR;
      day_table_r        <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_SHIFT_HOURS: rule_r.shift       <= pwdata[SHIFT_W-1:0];
        CFG_START_MONTH: rule_r.start_month <= pwdata[MONTH_W-1:0];
        CFG_START_HOUR:  rule_r.start_hour  <= pwdata[HOUR_W-1:0];
        CFG_END_MONTH:   rule_r.end_month   <= pwdata[MONTH_W-1:0];
        CFG_END_HOUR:    rule_r.end_hour    <= pwdata[HOUR_W-1:0];
        CFG_FIRST_YEAR:  first_year_r       <= pwdata[YEAR_W-1:0];
        CFG_DAY_TABLE:   day_table_r        <= pwdata[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      CFG_SHIFT_HOURS: prdata = CFG_DATA_W'(rule_r.shift);
      CFG_START_MONTH: prdata = CFG_DATA_W'(rule_r.start_month);
      CFG_START_HOUR:  prdata = CFG_DATA_W'(rule_r.start_hour);
      CFG_END_MONTH:   prdata = CFG_DATA_W'(rule_r.end_month);
      CFG_END_HOUR:    prdata = CFG_DATA_W'(rule_r.end_hour);
      CFG_FIRST_YEAR:  prdata = CFG_DATA_W'(first_year_r);
      CFG_DAY_TABLE:   prdata = CFG_DATA_W'(day_table_r);
      default:         prdata = '0;
    endcase
  end

  ccd_dst_lookup #(.DST_YEARS(DST_YEARS)) u_lookup (
    .year       (date_r.year),
    .first_year (first_year_r),
    .day_table  (day_table_r),
    .days       (days)
  );

  ccd_hour_step u_hour (
    .hour         (hour_r),
    .date         (date_r),
    .end_switched (end_sw_r),
    .rule         (rule_r),
    .days         (days),
    .res          (hour_res)
  );

  // Tick or load: next counter values.
  always_comb begin
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    date_nxt   = date_r;
    end_sw_nxt = end_sw_r;
    rolled_nxt = 1'b0;
    if (in_kind) begin
      sec_nxt       = in_load_second;
      min_nxt       = in_load_minute;
      hour_nxt      = in_load_hour;
      date_nxt.day  = in_load_day;
      date_nxt.month = in_load_month;
      date_nxt.year = in_load_year;
    end else if (sec_r >= LAST_SECOND) begin
      sec_nxt = '0;
      if (min_r >= LAST_MINUTE) begin
        min_nxt    = '0;
        hour_nxt   = hour_res.hour;
        date_nxt   = hour_res.date;
        end_sw_nxt = hour_res.end_switched;
        rolled_nxt = hour_res.rolled;
      end else begin
        min_nxt = min_r + 6'd1;
      end
    end else begin
      sec_nxt = sec_r + 6'd1;
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Counter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r          <= '0;
      min_r          <= '0;
      hour_r         <= '0;
      date_r.day     <= 5'd1;
      date_r.month   <= 4'd1;
      date_r.year    <= '0;
      end_sw_r       <= 1'b0;
    end else if (accept) begin
      sec_r    <= sec_nxt;
      min_r    <= min_nxt;
      hour_r   <= hour_nxt;
      date_r   <= date_nxt;
      end_sw_r <= end_sw_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_sec_r    <= sec_nxt;
      out_min_r    <= min_nxt;
      out_hour_r   <= hour_nxt;
      out_date_r   <= date_nxt;
      out_rolled_r <= rolled_nxt;
      out_end_r    <= end_sw_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_second       = out_sec_r;
  assign out_minute       = out_min_r;
  assign out_hour         = out_hour_r;
  assign out_day          = out_date_r.day;
  assign out_month        = out_date_r.month;
  assign out_year         = out_date_r.year;
  assign out_day_rolled   = out_rolled_r;
  assign out_dst_end_done = out_end_r;

endmodule

### src/ccd_checker.sv
module ccd_checker import ccd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SEC_W-1:0]  out_second,
  input logic [MIN_W-1:0]  out_minute,
  input logic [HOUR_W-1:0] out_hour,
  input logic              out_day_rolled,
  input logic              out_dst_end_done
);

  // A stalled result word keeps its time and day-rollover fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_second) &&
    $stable(out_minute) && $stable(out_hour) && $stable(out_day_rolled))
    else $error("stalled result word changed");

  // Input is taken whenever the result register is free or drains.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the result register");

  // Midnight happens only at the top of an hour, early in the new day.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_day_rolled |-> out_second == '0 && out_minute == '0 &&
    out_hour <= 5'd11)
    else $error("day rollover at an impossible time");

  // A new day starts with summer time not yet ended.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_day_rolled |-> !out_dst_end_done)
    else $error("end flag survived midnight");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind calendar_clock_with_dst_top ccd_checker u_ccd_checker (.*);

### bench/ccd_calendar_checker.sv
// Watches both channels of the calendar clock, predicts every result word
// from its own copy of the counters and the daylight-saving rule, and
// compares each accepted result word with the oldest prediction.
module ccd_calendar_checker import ccd_pkg::*; #(
  parameter int DST_YEARS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_kind,
  input  logic [SEC_W-1:0]      in_load_second,
  input  logic [MIN_W-1:0]      in_load_minute,
  input  logic [HOUR_W-1:0]     in_load_hour,
  input  logic [DAY_W-1:0]      in_load_day,
  input  logic [MONTH_W-1:0]    in_load_month,
  input  logic [YEAR_W-1:0]     in_load_year,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [SEC_W-1:0]      out_second,
  input  logic [MIN_W-1:0]      out_minute,
  input  logic [HOUR_W-1:0]     out_hour,
  input  logic [DAY_W-1:0]      out_day,
  input  logic [MONTH_W-1:0]    out_month,
  input  logic [YEAR_W-1:0]     out_year,
  input  logic                  out_day_rolled,
  input  logic                  out_dst_end_done,
  output int                    mismatch_count,
  output int                    pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               end_done;
  } cal_state_t;

  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               day_rolled;
    logic               dst_end_done;
  } cal_word_t;

  // Mirror of the configuration registers.
  logic [SHIFT_W-1:0] cfg_shift;
  logic [MONTH_W-1:0] cfg_start_month;
  logic [HOUR_W-1:0]  cfg_start_hour;
  logic [MONTH_W-1:0] cfg_end_month;
  logic [HOUR_W-1:0]  cfg_end_hour;
  logic [YEAR_W-1:0]  cfg_first_year;
  logic [TABLE_W-1:0] cfg_day_table;

  cal_state_t cal;
  cal_word_t  expected_words[$];

  // Days in a month; out-of-range month codes count as 31 days.
  function automatic int month_length(input logic [MONTH_W-1:0] m,
                                      input logic [YEAR_W-1:0] y);
    case (m)
      4'd2:                    return (y[1:0] == 2'b00) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default:                 return 31;
    endcase
  endfunction

  // The top-of-hour step: summer-time start and end, then the midnight rollover.
  function automatic cal_state_t hour_rollover(input cal_state_t s, output logic rolled);
    int               new_hour;
    int               idx;
    int               d;
    int               m;
    int               y;
    logic [ENTRY_W-1:0] entry;
    logic [DAY_W-1:0] start_day;
    logic [DAY_W-1:0] end_day;
    rolled    = 1'b0;
    new_hour  = int'(s.hour) + 1;
    start_day = '0;
    end_day   = '0;
    if (s.year >= cfg_first_year) begin
      idx = int'(s.year) - int'(cfg_first_year);
      if (idx < DST_YEARS && idx < TABLE_ENTRIES) begin
        entry     = cfg_day_table[ENTRY_W*idx +: ENTRY_W];
        start_day = entry[DAY_W-1:0];
        end_day   = entry[ENTRY_W-1:DAY_W];
      end
    end
    if (s.month == cfg_start_month && start_day != '0 && s.day == start_day &&
        new_hour == int'(cfg_start_hour)) begin
      new_hour = new_hour + int'(cfg_shift);
    end
    if (!s.end_done && s.month == cfg_end_month && end_day != '0 && s.day == end_day &&
        new_hour == int'(cfg_end_hour)) begin
      s.end_done = 1'b1;
      new_hour   = (new_hour >= int'(cfg_shift)) ? new_hour - int'(cfg_shift) : 0;
    end
    if (new_hour >= 24) begin
      d          = int'(s.day) + 1;
      m          = int'(s.month);
      y          = int'(s.year);
      s.end_done = 1'b0;
      rolled     = 1'b1;
      new_hour   = new_hour - 24;
      if (d > month_length(s.month, s.year)) begin
        d = 1;
        m = m + 1;
        if (m >= 13) begin
          m = 1;
          y = (y >= 99) ? 0 : y + 1;
        end
      end
      s.day   = DAY_W'(d);
      s.month = MONTH_W'(m);
      s.year  = YEAR_W'(y);
    end
    s.hour = HOUR_W'(new_hour);
    return s;
  endfunction

  function automatic string word_text(input cal_word_t w);
    return $sformatf("%0d:%0d:%0d %0d/%0d/%0d rolled=%0d end_done=%0d", w.hour, w.minute,
                     w.second, w.day, w.month, w.year, w.day_rolled, w.dst_end_done);
  endfunction

  always @(posedge clk) begin
    cal_word_t want;
    cal_word_t got;
    logic      rolled;
    if (!rst_n) begin
      cfg_shift       = RST_SHIFT_HOURS;
      cfg_start_month = RST_START_MONTH;
      cfg_start_hour  = RST_START_HOUR;
      cfg_end_month   = RST_END_MONTH;
      cfg_end_hour    = RST_END_HOUR;
      cfg_first_year  = RST_FIRST_YEAR;
      cfg_day_table   = '0;
      cal             = '{second: '0, minute: '0, hour: '0, day: 5'd1, month: 4'd1,
                          year: '0, end_done: 1'b0};
      expected_words.delete();
      mismatch_count  = 0;
      pending_words  <= 0;
    end else begin
      // Register writes take effect for every later word.
      if (psel && penable && pwrite && pready) begin
        case (ccd_cfg_index_t'(paddr[CFG_ADDR_W-1:3]))
          CFG_SHIFT_HOURS: cfg_shift       = pwdata[SHIFT_W-1:0];
          CFG_START_MONTH: cfg_start_month = pwdata[MONTH_W-1:0];
          CFG_START_HOUR:  cfg_start_hour  = pwdata[HOUR_W-1:0];
          CFG_END_MONTH:   cfg_end_month   = pwdata[MONTH_W-1:0];
          CFG_END_HOUR:    cfg_end_hour    = pwdata[HOUR_W-1:0];
          CFG_FIRST_YEAR:  cfg_first_year  = pwdata[YEAR_W-1:0];
          CFG_DAY_TABLE:   cfg_day_table   = pwdata[TABLE_W-1:0];
          default: ;
        endcase
      end

      // Compare an accepted result word with the oldest prediction.
      if (out_valid && out_ready) begin
        got = '{out_second, out_minute, out_hour, out_day, out_month, out_year,
                out_day_rolled, out_dst_end_done};
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected, actual %s", $time, word_text(got));
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %s, actual %s", $time,
                     word_text(want), word_text(got));
            mismatch_count++;
          end
        end
      end

      // Advance the predicted counters for an accepted input word.
      if (in_valid && in_ready) begin
        rolled = 1'b0;
        if (in_kind) begin
          cal.second = in_load_second;
          cal.minute = in_load_minute;
          cal.hour   = in_load_hour;
          cal.day    = in_load_day;
          cal.month  = in_load_month;
          cal.year   = in_load_year;
        end else if (cal.second >= LAST_SECOND) begin
          cal.second = '0;
          if (cal.minute >= LAST_MINUTE) begin
            cal.minute = '0;
            cal = hour_rollover(cal, rolled);
          end else begin
            cal.minute = cal.minute + 1'b1;
          end
        end else begin
          cal.second = cal.second + 1'b1;
        end
        expected_words.push_back('{cal.second, cal.minute, cal.hour, cal.day, cal.month,
                                   cal.year, rolled, cal.end_done});
      end
      pending_words <= expected_words.size();
    end
  end

endmodule

### bench/tb_calendar_clock_with_dst_top.sv
module tb_calendar_clock_with_dst_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ccd_pkg::*;

  localparam int DST_YEARS         = 6;
  localparam int WORDS_PER_SETTING = 156;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  in_kind        = 1'b0;
  logic [SEC_W-1:0]      in_load_second = '0;
  logic [MIN_W-1:0]      in_load_minute = '0;
  logic [HOUR_W-1:0]     in_load_hour   = '0;
  logic [DAY_W-1:0]      in_load_day    = '0;
  logic [MONTH_W-1:0]    in_load_month  = '0;
  logic [YEAR_W-1:0]     in_load_year   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SEC_W-1:0]      out_second;
  logic [MIN_W-1:0]      out_minute;
  logic [HOUR_W-1:0]     out_hour;
  logic [DAY_W-1:0]      out_day;
  logic [MONTH_W-1:0]    out_month;
  logic [YEAR_W-1:0]     out_year;
  logic                  out_day_rolled;
  logic                  out_dst_end_done;
  int                    mismatch_count;
  int                    pending_words;

  // Sender idle and receiver stall chances, in percent per cycle.
  int idle_pct  = 0;
  int stall_pct = 0;
  int setting_words;

  // Copy of the rule last written, used to aim loads at the switch hours.
  logic [SHIFT_W-1:0] rule_shift;
  logic [MONTH_W-1:0] rule_start_month;
  logic [HOUR_W-1:0]  rule_start_hour;
  logic [MONTH_W-1:0] rule_end_month;
  logic [HOUR_W-1:0]  rule_end_hour;
  logic [YEAR_W-1:0]  rule_first_year;
  logic [TABLE_W-1:0] rule_table;

  calendar_clock_with_dst_top #(.DST_YEARS(DST_YEARS)) u_top (.*);

  ccd_calendar_checker #(.DST_YEARS(DST_YEARS)) u_checker (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // One register write: a setup phase, an access phase held until pready, then a bus idle phase.
  task automatic cfg_write(input ccd_cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_rule(input logic [SHIFT_W-1:0] shift,
                            input logic [MONTH_W-1:0] start_month,
                            input logic [HOUR_W-1:0] start_hour,
                            input logic [MONTH_W-1:0] end_month,
                            input logic [HOUR_W-1:0] end_hour,
                            input logic [YEAR_W-1:0] first_year,
                            input logic [TABLE_W-1:0] day_table);
    rule_shift       = shift;
    rule_start_month = start_month;
    rule_start_hour  = start_hour;
    rule_end_month   = end_month;
    rule_end_hour    = end_hour;
    rule_first_year  = first_year;
    rule_table       = day_table;
    cfg_write(CFG_SHIFT_HOURS, CFG_DATA_W'(shift));
    cfg_write(CFG_START_MONTH, CFG_DATA_W'(start_month));
    cfg_write(CFG_START_HOUR, CFG_DATA_W'(start_hour));
    cfg_write(CFG_END_MONTH, CFG_DATA_W'(end_month));
    cfg_write(CFG_END_HOUR, CFG_DATA_W'(end_hour));
    cfg_write(CFG_FIRST_YEAR, CFG_DATA_W'(first_year));
    cfg_write(CFG_DAY_TABLE, CFG_DATA_W'(day_table));
  endtask

  // A random rule; now and then the end falls on the same day as the start.
  task automatic random_rule();
    logic [TABLE_W-1:0] tbl;
    logic [MONTH_W-1:0] sm;
    logic [MONTH_W-1:0] em;
    tbl = TABLE_W'({$urandom, $urandom});
    sm  = MONTH_W'($urandom_range(1, 12));
    em  = MONTH_W'($urandom_range(1, 12));
    if ($urandom_range(3) == 0) begin
      em = sm;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl[ENTRY_W*i + DAY_W +: DAY_W] = tbl[ENTRY_W*i +: DAY_W];
      end
    end
    apply_rule(SHIFT_W'($urandom), sm, HOUR_W'($urandom_range(23)), em,
               HOUR_W'($urandom_range(23)), YEAR_W'($urandom_range(99)), tbl);
  endtask

  // Offer one word, after a random idle gap, and hold it until it is taken.
  task automatic send_word(input logic kind, input logic [SEC_W-1:0] s,
                           input logic [MIN_W-1:0] mi, input logic [HOUR_W-1:0] h,
                           input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] mo,
                           input logic [YEAR_W-1:0] y);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_load_second <= s;
    in_load_minute <= mi;
    in_load_hour   <= h;
    in_load_day    <= d;
    in_load_month  <= mo;
    in_load_year   <= y;
    do @(posedge clk); while (!in_ready);
    setting_words++;
  endtask

  // A tick carries random, ignored load fields.
  task automatic send_tick();
    send_word(1'b0, SEC_W'($urandom), MIN_W'($urandom), HOUR_W'($urandom),
              DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom));
  endtask

  task automatic send_load(input logic [SEC_W-1:0] s, input logic [MIN_W-1:0] mi,
                           input logic [HOUR_W-1:0] h, input logic [DAY_W-1:0] d,
                           input logic [MONTH_W-1:0] mo, input logic [YEAR_W-1:0] y);
    send_word(1'b1, s, mi, h, d, mo, y);
  endtask

  // Stop offering words and wait for every predicted result word.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (2) @(posedge clk);
  endtask

  // Random traffic under one rule: mostly loads aimed at a switch or at
  // midnight followed by ticks, plus raw loads and plain tick runs.
  task automatic run_setting(input int quota);
    int                 pick;
    int                 idx;
    logic               use_end;
    logic [ENTRY_W-1:0] entry;
    logic [HOUR_W-1:0]  hr;
    logic [DAY_W-1:0]   dy;
    logic [MONTH_W-1:0] mo;
    logic [YEAR_W-1:0]  yr;
    setting_words = 0;
    while (setting_words < quota) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        idx     = $urandom_range(TABLE_ENTRIES - 1);
        entry   = rule_table[ENTRY_W*idx +: ENTRY_W];
        use_end = 1'($urandom_range(1));
        mo      = use_end ? rule_end_month : rule_start_month;
        dy      = use_end ? entry[ENTRY_W-1:DAY_W] : entry[DAY_W-1:0];
        hr      = (use_end ? rule_end_hour : rule_start_hour) - 5'd1;
        yr      = rule_first_year + YEAR_W'(idx);
        if ($urandom_range(3) == 0) begin
          yr = ($urandom_range(1) != 0) ? rule_first_year + YEAR_W'(DST_YEARS)
                                        : rule_first_year - 7'd1;
        end
        send_load(SEC_W'($urandom_range(57, 59)), LAST_MINUTE, hr, dy, mo, yr);
        repeat ($urandom_range(1, 4)) send_tick();
        // Same day again, just before the switch hour or just before midnight.
        if ($urandom_range(1) != 0) begin
          send_load(LAST_SECOND, LAST_MINUTE, ($urandom_range(1) != 0) ? hr : 5'd23,
                    dy, mo, yr);
          send_tick();
        end
      end else if (pick < 75) begin
        mo = ($urandom_range(7) == 0) ? MONTH_W'($urandom) : MONTH_W'($urandom_range(1, 12));
        dy = ($urandom_range(1) != 0) ? DAY_W'($urandom_range(28, 31)) : DAY_W'($urandom);
        yr = ($urandom_range(3) == 0) ? YEAR_W'($urandom_range(96, 127))
                                      : YEAR_W'($urandom_range(99));
        send_load(SEC_W'($urandom_range(57, 59)), LAST_MINUTE, 5'd23, dy, mo, yr);
        repeat ($urandom_range(1, 4)) send_tick();
      end else if (pick < 88) begin
        send_load(SEC_W'($urandom), MIN_W'($urandom), HOUR_W'($urandom), DAY_W'($urandom),
                  MONTH_W'($urandom), YEAR_W'($urandom));
        repeat ($urandom_range(3)) send_tick();
      end else begin
        repeat ($urandom_range(10, 40)) send_tick();
      end
    end
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 79, 0, 15};
    stall_tab = '{0, 0, 79, 15};
    rule_shift       = RST_SHIFT_HOURS;
    rule_start_month = RST_START_MONTH;
    rule_start_hour  = RST_START_HOUR;
    rule_end_month   = RST_END_MONTH;
    rule_end_hour    = RST_END_HOUR;
    rule_first_year  = RST_FIRST_YEAR;
    rule_table       = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, all-ones fields, calendar rollovers under the reset rule.
    send_tick();
    send_load(6'd63, 6'd63, 5'd31, 5'd31, 4'd15, 7'd127);
    send_tick();
    send_load(6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 7'd99);
    send_tick();
    send_load(6'd59, 6'd59, 5'd23, 5'd28, 4'd2, 7'd4);
    send_tick();
    send_load(6'd59, 6'd59, 5'd23, 5'd29, 4'd2, 7'd4);
    send_tick();
    send_load(6'd59, 6'd59, 5'd23, 5'd30, 4'd2, 7'd1);
    send_tick();
    send_load(6'd59, 6'd59, 5'd23, 5'd0, 4'd0, 7'd0);
    send_tick();
    drain();

    // Switch cases: start past midnight, end saturating at zero, end only
    // once per day across a load, a zero table entry, years off the table.
    apply_rule(2'd3, 4'd3, 5'd23, 4'd10, 5'd1, 7'd9,
               {10'h3FF, 10'h0B3, 10'h15A, 10'h2A5, 10'h000, 10'd229});
    send_load(6'd59, 6'd59, 5'd22, 5'd5, 4'd3, 7'd9);
    send_tick();
    send_load(6'd59, 6'd59, 5'd0, 5'd7, 4'd10, 7'd9);
    send_tick();
    send_load(6'd59, 6'd59, 5'd0, 5'd7, 4'd10, 7'd9);
    send_tick();
    send_load(6'd59, 6'd59, 5'd22, 5'd5, 4'd3, 7'd10);
    send_tick();
    send_load(6'd59, 6'd59, 5'd22, 5'd5, 4'd3, 7'd8);
    send_tick();
    send_load(6'd59, 6'd59, 5'd22, 5'd5, 4'd3, 7'd15);
    send_tick();
    drain();

    // Random part: every idling mix, two rules each; the first two mixes each open with an extreme rule.
    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 2; c++) begin
        if (p == 0 && c == 0) begin
          apply_rule(2'd3, 4'd12, 5'd23, 4'd12, 5'd23, 7'd99, {TABLE_W{1'b1}});
        end else if (p == 1 && c == 0) begin
          apply_rule(2'd0, 4'd1, 5'd0, 4'd1, 5'd0, 7'd0, '0);
        end else begin
          random_rule();
        end
        idle_pct  = idle_tab[p];
        stall_pct = stall_tab[p];
        run_setting(WORDS_PER_SETTING);
        drain();
      end
    end

    if (mismatch_count == 0) begin
      $display("tb_calendar_clock_with_dst_top: PASS");
    end else begin
      $display("tb_calendar_clock_with_dst_top: FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("tb_calendar_clock_with_dst_top: FAIL");
    $finish;
  end

endmodule
